[rtl/uer_pkg.sv]
package uer_pkg;

    // Width of the wait and pulse timers
    localparam int TIMER_BITS = 20;

    // Field widths
    localparam int TRIG_BITS  = 10;
    localparam int TMO_BITS   = 20;
    localparam int DIV_BITS   = 8;
    localparam int WIDTH_BITS = 20;
    localparam int RANGE_BITS = 19;

    // Configuration port
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_TICKS  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ECHO_TIMEOUT   = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICKS_PER_CM   = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICKS_PER_INCH = 4'd3;

    localparam logic [TRIG_BITS-1:0] RST_TRIGGER_TICKS  = 10'd10;
    localparam logic [TMO_BITS-1:0]  RST_ECHO_TIMEOUT   = 20'd30000;
    localparam logic [DIV_BITS-1:0]  RST_TICKS_PER_CM   = 8'd29;
    localparam logic [DIV_BITS-1:0]  RST_TICKS_PER_INCH = 8'd74;

    // Trigger low lead-in, in ticks
    localparam int TRIG_LOW_TICKS = 2;

    // One quotient bit per divide step
    localparam int DIV_STEPS    = WIDTH_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    typedef struct packed {
        logic tick;         // apply one tick to the ranger state
        logic load_direct;  // load output word from the tick result
        logic div_step;     // advance both dividers one bit
        logic load_div;     // load output word from the held result and quotients
    } t_dp_cmd;

    typedef struct packed {
        logic done;         // current tick completes a measurement
    } t_dp_stat;

endpackage

[rtl/uer_if.sv]
interface uer_in_if;
    logic valid;
    logic ready;
    logic cmd;
    logic echo_level;

    modport source (output valid, output cmd, output echo_level, input ready);
    modport sink   (input valid, input cmd, input echo_level, output ready);
endinterface

interface uer_out_if;
    logic                            valid;
    logic                            ready;
    logic                            trigger_level;
    logic                            busy_res;
    logic                            done_res;
    logic                            timed_out;
    logic [uer_pkg::WIDTH_BITS-1:0]  echo_width;
    logic [uer_pkg::RANGE_BITS-1:0]  range_cm;
    logic [uer_pkg::RANGE_BITS-1:0]  range_inch;

    modport source (output valid, output trigger_level, output busy_res, output done_res,
                    output timed_out, output echo_width, output range_cm,
                    output range_inch, input ready);
    modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                    input timed_out, input echo_width, input range_cm,
                    input range_inch, output ready);
endinterface

interface uer_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [uer_pkg::CFG_IDX_BITS-1:0]   index;
    logic [uer_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/uer_ctrl.sv]
module uer_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  uer_pkg::t_dp_stat i_stat,
    output uer_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_RUN  = 3'b001,
        S_DIV  = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state                           r_state, n_state;
    logic [uer_pkg::DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic                             r_out_valid, n_out_valid;
    logic                             room;
    logic                             accept;

    assign room        = !r_out_valid || i_out_ready;
    assign o_in_ready  = i_rst_n && (r_state == S_RUN) && room;
    assign accept      = o_in_ready && i_in_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state           = r_state;
        n_cnt             = r_cnt;
        o_cmd             = '0;
        o_cmd.tick        = accept;
        case (r_state)
            S_RUN: begin
                if (accept) begin
                    if (i_stat.done) begin
                        n_state = S_DIV;
                        n_cnt   = '0;
                    end else begin
                        o_cmd.load_direct = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == uer_pkg::DIV_CNT_BITS'(uer_pkg::DIV_STEPS - 1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (room) begin
                    o_cmd.load_div = 1'b1;
                    n_state        = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_direct || o_cmd.load_div) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/uer_dp.sv]
module uer_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  uer_pkg::t_dp_cmd                 i_cmd,
    output uer_pkg::t_dp_stat                o_stat,
    input  logic                             i_cmd_start,
    input  logic                             i_echo_level,
    input  logic                             i_cfg_valid,
    input  logic [uer_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [uer_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                             o_trigger_level,
    output logic                             o_busy_res,
    output logic                             o_done_res,
    output logic                             o_timed_out,
    output logic [uer_pkg::WIDTH_BITS-1:0]   o_echo_width,
    output logic [uer_pkg::RANGE_BITS-1:0]   o_range_cm,
    output logic [uer_pkg::RANGE_BITS-1:0]   o_range_inch
);

    typedef enum logic [5:0] {
        PH_IDLE       = 6'b000001,
        PH_TRIG_LOW   = 6'b000010,
        PH_TRIG_HIGH  = 6'b000100,
        PH_WAIT_END   = 6'b001000,
        PH_WAIT_START = 6'b010000,
        PH_MEASURE    = 6'b100000
    } t_phase;

    localparam int TB = uer_pkg::TIMER_BITS;
    localparam int WB = uer_pkg::WIDTH_BITS;
    localparam int DB = uer_pkg::DIV_BITS;
    localparam int RB = uer_pkg::RANGE_BITS;
    localparam int PB = uer_pkg::TRIG_BITS;

    // Configuration
    logic [PB-1:0]                r_trigger_ticks;
    logic [uer_pkg::TMO_BITS-1:0] r_echo_timeout;
    logic [DB-1:0]                r_ticks_per_cm;
    logic [DB-1:0]                r_ticks_per_inch;

    // Ranger state
    t_phase        r_phase, n_phase;
    logic [PB-1:0] r_phase_count, n_phase_count;
    logic [TB-1:0] r_elapsed, n_elapsed;
    logic [TB-1:0] r_pulse_width, n_pulse_width;

    // Tick result
    logic          t_trig, t_busy, t_done, t_tmo, fin;
    logic [WB-1:0] t_width;

    // Held result for divided words
    logic          r_res_trig, r_res_busy, r_res_tmo;
    logic [WB-1:0] r_res_width;

    // Dividers
    logic [WB-1:0] r_q_cm, r_q_inch;
    logic [DB-1:0] r_rem_cm, r_rem_inch;
    logic [DB:0]   sh_cm, sh_inch;
    logic          ge_cm, ge_inch;

    always_comb begin
        n_phase       = r_phase;
        n_phase_count = r_phase_count;
        n_elapsed     = r_elapsed;
        n_pulse_width = r_pulse_width;
        t_trig        = 1'b0;
        t_busy        = 1'b1;
        t_done        = 1'b0;
        t_tmo         = 1'b0;
        t_width       = '0;
        fin           = 1'b0;
        if (n_phase == PH_IDLE && i_cmd_start) begin
            n_phase       = PH_TRIG_LOW;
            n_phase_count = '0;
        end
        case (n_phase)
            PH_TRIG_LOW: begin
                n_phase_count = n_phase_count + 1'b1;
                if (n_phase_count >= PB'(uer_pkg::TRIG_LOW_TICKS)) begin
                    n_phase       = PH_TRIG_HIGH;
                    n_phase_count = '0;
                end
            end
            PH_TRIG_HIGH: begin
                t_trig        = 1'b1;
                n_phase_count = n_phase_count + 1'b1;
                if (n_phase_count >= r_trigger_ticks) begin
                    n_phase       = PH_WAIT_END;
                    n_phase_count = '0;
                    n_elapsed     = '0;
                    n_pulse_width = '0;
                end
            end
            PH_WAIT_END, PH_WAIT_START, PH_MEASURE: begin
                if (n_phase == PH_WAIT_END) begin
                    if (!i_echo_level) begin
                        n_phase = PH_WAIT_START;
                    end
                end else if (n_phase == PH_WAIT_START) begin
                    if (i_echo_level) begin
                        n_phase       = PH_MEASURE;
                        n_pulse_width = TB'(1);
                    end
                end else begin
                    if (i_echo_level) begin
                        n_pulse_width = n_pulse_width + 1'b1;
                    end else begin
                        fin     = 1'b1;
                        t_width = WB'(n_pulse_width);
                    end
                end
                if (!fin) begin
                    n_elapsed = n_elapsed + 1'b1;
                    if (32'(n_elapsed) >= 32'(r_echo_timeout)) begin
                        fin     = 1'b1;
                        t_tmo   = 1'b1;
                        t_width = '0;
                    end
                end
                if (fin) begin
                    t_done        = 1'b1;
                    n_phase       = PH_IDLE;
                    n_phase_count = '0;
                end
            end
            default: begin
                t_busy  = 1'b0;
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign o_stat.done = t_done;

    // Restoring divide step: one quotient bit per cycle
    assign sh_cm   = {r_rem_cm, r_q_cm[WB-1]};
    assign sh_inch = {r_rem_inch, r_q_inch[WB-1]};
    assign ge_cm   = sh_cm >= {1'b0, r_ticks_per_cm};
    assign ge_inch = sh_inch >= {1'b0, r_ticks_per_inch};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks  <= uer_pkg::RST_TRIGGER_TICKS;
            r_echo_timeout   <= uer_pkg::RST_ECHO_TIMEOUT;
            r_ticks_per_cm   <= uer_pkg::RST_TICKS_PER_CM;
            r_ticks_per_inch <= uer_pkg::RST_TICKS_PER_INCH;
            r_phase          <= PH_IDLE;
            r_phase_count    <= '0;
            r_elapsed        <= '0;
            r_pulse_width    <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    uer_pkg::CFG_TRIGGER_TICKS:  r_trigger_ticks  <= i_cfg_data[PB-1:0];
                    uer_pkg::CFG_ECHO_TIMEOUT:   r_echo_timeout   <= i_cfg_data;
                    uer_pkg::CFG_TICKS_PER_CM:   r_ticks_per_cm   <= i_cfg_data[DB-1:0];
                    uer_pkg::CFG_TICKS_PER_INCH: r_ticks_per_inch <= i_cfg_data[DB-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.tick) begin
                r_phase       <= n_phase;
                r_phase_count <= n_phase_count;
                r_elapsed     <= n_elapsed;
                r_pulse_width <= n_pulse_width;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick && t_done) begin
            r_res_trig  <= t_trig;
            r_res_busy  <= t_busy;
            r_res_tmo   <= t_tmo;
            r_res_width <= t_width;
            r_q_cm      <= t_width;
            r_q_inch    <= t_width;
            r_rem_cm    <= '0;
            r_rem_inch  <= '0;
        end else if (i_cmd.div_step) begin
            r_q_cm     <= {r_q_cm[WB-2:0], ge_cm};
            r_q_inch   <= {r_q_inch[WB-2:0], ge_inch};
            r_rem_cm   <= ge_cm ? DB'(sh_cm - {1'b0, r_ticks_per_cm}) : sh_cm[DB-1:0];
            r_rem_inch <= ge_inch ? DB'(sh_inch - {1'b0, r_ticks_per_inch})
                                  : sh_inch[DB-1:0];
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_direct) begin
            o_trigger_level <= t_trig;
            o_busy_res      <= t_busy;
            o_done_res      <= 1'b0;
            o_timed_out     <= 1'b0;
            o_echo_width    <= '0;
            o_range_cm      <= '0;
            o_range_inch    <= '0;
        end else if (i_cmd.load_div) begin
            o_trigger_level <= r_res_trig;
            o_busy_res      <= r_res_busy;
            o_done_res      <= 1'b1;
            o_timed_out     <= r_res_tmo;
            o_echo_width    <= r_res_width;
            o_range_cm      <= r_q_cm[WB-1 -: RB];
            o_range_inch    <= r_q_inch[WB-1 -: RB];
        end
    end

endmodule

[rtl/ultrasonic_echo_ranger_top.sv]
// Channel  Dir  Fields                                              Handshake
// i_in     in   cmd, echo_level                                     valid/ready
// o_out    out  trigger_level, busy_res, done_res, timed_out,       valid/ready
//               echo_width, range_cm, range_inch
// i_cfg    in   index, data                                         valid/ready, ready high
//
// Each input word is one tick and yields exactly one output word. A tick
// that does not complete a measurement has its word registered in the
// cycle after it is taken. A completing tick runs the two 20-step
// restoring dividers before its word is loaded. The next tick is taken
// as soon as the previous word sits in the output register and is leaving.
// Reset (synchronous, active low) returns the ranger to idle and restores
// register defaults; both ready lines stay low while reset is held; a stalled
// output holds its word and blocks new ticks.
module ultrasonic_echo_ranger_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uer_in_if.sink      i_in,
    uer_out_if.source   o_out,
    uer_cfg_if.sink     i_cfg
);

    uer_pkg::t_dp_cmd  cmd;
    uer_pkg::t_dp_stat stat;

    // Registers take a write every cycle outside reset
    assign i_cfg.ready = i_rst_n;

    // Sequence accept, divide and output load
    uer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Ranger phases, timers, dividers and the output word
    uer_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cmd_start     (i_in.cmd),
        .i_echo_level    (i_in.echo_level),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_trigger_level (o_out.trigger_level),
        .o_busy_res      (o_out.busy_res),
        .o_done_res      (o_out.done_res),
        .o_timed_out     (o_out.timed_out),
        .o_echo_width    (o_out.echo_width),
        .o_range_cm      (o_out.range_cm),
        .o_range_inch    (o_out.range_inch)
    );

endmodule

[test/uer_ranger_checker.sv]
module uer_ranger_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    uer_in_if    i_tick,
    uer_out_if   i_word,
    uer_cfg_if   i_cfg,
    output int   o_mismatches,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        RG_IDLE       = 3'd0,
        RG_TRIG_LOW   = 3'd1,
        RG_TRIG_HIGH  = 3'd2,
        RG_WAIT_END   = 3'd3,
        RG_WAIT_START = 3'd4,
        RG_MEASURE    = 3'd5
    } t_ranger_phase;

    typedef struct packed {
        logic                           trig;
        logic                           busy;
        logic                           done;
        logic                           tmo;
        logic [uer_pkg::WIDTH_BITS-1:0] width;
        logic [uer_pkg::RANGE_BITS-1:0] cm;
        logic [uer_pkg::RANGE_BITS-1:0] inch;
    } t_tick_word;

    logic [uer_pkg::TRIG_BITS-1:0]  trig_len;
    logic [uer_pkg::TMO_BITS-1:0]   echo_budget;
    logic [uer_pkg::DIV_BITS-1:0]   cm_div;
    logic [uer_pkg::DIV_BITS-1:0]   inch_div;

    t_ranger_phase                  phase;
    logic [uer_pkg::TRIG_BITS-1:0]  phase_cnt;
    logic [uer_pkg::TIMER_BITS-1:0] elapsed;
    logic [uer_pkg::TIMER_BITS-1:0] pulse_len;

    t_tick_word            tick_words_q[$];
    int                    mismatch_count = 0;
    int                    pending_words  = 0;
    int                    word_idx       = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_words;

    // Divide by zero saturates the quotient to all ones
    function automatic logic [uer_pkg::RANGE_BITS-1:0] halved_range(
        input logic [uer_pkg::WIDTH_BITS-1:0] width,
        input logic [uer_pkg::DIV_BITS-1:0]   div);
        logic [uer_pkg::WIDTH_BITS-1:0] quot;
        quot = (div == '0) ? '1 : width / div;
        return quot[uer_pkg::WIDTH_BITS-1:1];
    endfunction

    // Advance the ranger by one tick and return the word it produces
    function automatic t_tick_word ranger_tick(input logic start, input logic echo);
        t_tick_word w;
        logic       finished;
        w        = '0;
        w.busy   = 1'b1;
        finished = 1'b0;
        if (phase == RG_IDLE && start) begin
            phase     = RG_TRIG_LOW;
            phase_cnt = '0;
        end
        case (phase)
            RG_TRIG_LOW: begin
                phase_cnt = phase_cnt + 1'b1;
                if (phase_cnt >= uer_pkg::TRIG_LOW_TICKS) begin
                    phase     = RG_TRIG_HIGH;
                    phase_cnt = '0;
                end
            end
            RG_TRIG_HIGH: begin
                w.trig    = 1'b1;
                phase_cnt = phase_cnt + 1'b1;
                if (phase_cnt >= trig_len) begin
                    phase     = RG_WAIT_END;
                    phase_cnt = '0;
                    elapsed   = '0;
                    pulse_len = '0;
                end
            end
            RG_WAIT_END, RG_WAIT_START, RG_MEASURE: begin
                case (phase)
                    RG_WAIT_END: if (!echo) phase = RG_WAIT_START;
                    RG_WAIT_START: if (echo) begin
                        phase     = RG_MEASURE;
                        pulse_len = uer_pkg::TIMER_BITS'(1);
                    end
                    default: if (echo) begin
                        pulse_len = pulse_len + 1'b1;
                    end else begin
                        finished = 1'b1;
                        w.width  = pulse_len;
                    end
                endcase
                if (!finished) begin
                    elapsed = elapsed + 1'b1;
                    if (elapsed >= echo_budget) begin
                        finished = 1'b1;
                        w.tmo    = 1'b1;
                        w.width  = '0;
                    end
                end
                if (finished) begin
                    w.done    = 1'b1;
                    phase     = RG_IDLE;
                    phase_cnt = '0;
                end
            end
            default: w.busy = 1'b0;
        endcase
        if (w.done) begin
            w.cm   = halved_range(w.width, cm_div);
            w.inch = halved_range(w.width, inch_div);
        end
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_word(input t_tick_word want);
        if (i_word.trigger_level !== want.trig)
            report_mismatch($sformatf("word %0d trigger_level got %0d want %0d",
                                      word_idx, i_word.trigger_level, want.trig));
        if (i_word.busy_res !== want.busy)
            report_mismatch($sformatf("word %0d busy_res got %0d want %0d",
                                      word_idx, i_word.busy_res, want.busy));
        if (i_word.done_res !== want.done)
            report_mismatch($sformatf("word %0d done_res got %0d want %0d",
                                      word_idx, i_word.done_res, want.done));
        if (i_word.timed_out !== want.tmo)
            report_mismatch($sformatf("word %0d timed_out got %0d want %0d",
                                      word_idx, i_word.timed_out, want.tmo));
        if (i_word.echo_width !== want.width)
            report_mismatch($sformatf("word %0d echo_width got %0d want %0d",
                                      word_idx, i_word.echo_width, want.width));
        if (i_word.range_cm !== want.cm)
            report_mismatch($sformatf("word %0d range_cm got %0d want %0d",
                                      word_idx, i_word.range_cm, want.cm));
        if (i_word.range_inch !== want.inch)
            report_mismatch($sformatf("word %0d range_inch got %0d want %0d",
                                      word_idx, i_word.range_inch, want.inch));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            trig_len    = uer_pkg::RST_TRIGGER_TICKS;
            echo_budget = uer_pkg::RST_ECHO_TIMEOUT;
            cm_div      = uer_pkg::RST_TICKS_PER_CM;
            inch_div    = uer_pkg::RST_TICKS_PER_INCH;
            phase       = RG_IDLE;
            phase_cnt   = '0;
            elapsed     = '0;
            pulse_len   = '0;
            tick_words_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    uer_pkg::CFG_TRIGGER_TICKS:
                        trig_len    = i_cfg.data[uer_pkg::TRIG_BITS-1:0];
                    uer_pkg::CFG_ECHO_TIMEOUT:
                        echo_budget = i_cfg.data[uer_pkg::TMO_BITS-1:0];
                    uer_pkg::CFG_TICKS_PER_CM:
                        cm_div      = i_cfg.data[uer_pkg::DIV_BITS-1:0];
                    uer_pkg::CFG_TICKS_PER_INCH:
                        inch_div    = i_cfg.data[uer_pkg::DIV_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_word.valid && i_word.ready) begin
                if (tick_words_q.size() == 0)
                    report_mismatch($sformatf("word %0d arrived with no tick pending",
                                              word_idx));
                else
                    compare_word(tick_words_q.pop_front());
                word_idx++;
            end
            if (i_tick.valid && i_tick.ready)
                tick_words_q.push_back(ranger_tick(i_tick.cmd, i_tick.echo_level));
        end
        pending_words <= tick_words_q.size();
    end

endmodule

[test/ultrasonic_echo_ranger_top_tb.sv]
module ultrasonic_echo_ranger_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to hold after the last word so a late divide can surface
    localparam int SETTLE_CYCLES = 40;
    // Cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT   = 2000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    uer_in_if  tick_ch();
    uer_out_if word_ch();
    uer_cfg_if cfg_ch();

    int mismatches;
    int words_pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int tick_count     = 0;
    int idle_cycles    = 0;
    int trig_len_now   = int'(uer_pkg::RST_TRIGGER_TICKS);

    ultrasonic_echo_ranger_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_out   (word_ch),
        .i_cfg   (cfg_ch)
    );

    uer_ranger_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_ch),
        .i_word       (word_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatches),
        .o_pending    (words_pending)
    );

    always #2 i_clk = ~i_clk;

    // Drop ready at random for the share of cycles the current phase asks
    always @(posedge i_clk) begin
        word_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: any handshake on any channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_ch.valid && tick_ch.ready) || (word_ch.valid && word_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one tick word, idling the sender at random first; leave valid high
    // on return so back-to-back ticks never drop it
    task automatic send_tick(input logic cmd_bit, input logic echo_bit);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.cmd        <= cmd_bit;
        tick_ch.echo_level <= echo_bit;
        do @(posedge i_clk); while (!tick_ch.ready);
        tick_count++;
    endtask

    task automatic write_reg(input logic [uer_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [uer_pkg::CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Write all four registers back to back, then drop valid once
    task automatic program_ranger(input int trig, input int budget_ticks,
                                  input int cm, input int inch);
        write_reg(uer_pkg::CFG_TRIGGER_TICKS, uer_pkg::CFG_DATA_BITS'(trig));
        write_reg(uer_pkg::CFG_ECHO_TIMEOUT, uer_pkg::CFG_DATA_BITS'(budget_ticks));
        write_reg(uer_pkg::CFG_TICKS_PER_CM, uer_pkg::CFG_DATA_BITS'(cm));
        write_reg(uer_pkg::CFG_TICKS_PER_INCH, uer_pkg::CFG_DATA_BITS'(inch));
        cfg_ch.valid <= 1'b0;
        trig_len_now = trig;
    endtask

    // Stop sending, wait for every expected word, then hold for the divider
    task automatic settle();
        tick_ch.valid <= 1'b0;
        do @(posedge i_clk); while (words_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly a well-formed measurement: start, ride out the trigger, an
    // optional pulse already in flight, a low gap, the echo pulse and its
    // falling edge. Filler ticks carry a random command so starts while busy
    // and restarts after a timeout show up too. The rest is plain noise.
    task automatic random_sequence();
        int sel;
        int pre;
        int gap;
        int pulse;
        int trig_span;
        sel = $urandom_range(99);
        if (sel < 15) begin
            repeat ($urandom_range(1, 8))
                send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
            trig_span = (trig_len_now == 0) ? 1 : trig_len_now;
            pre       = ($urandom_range(2) == 0) ? $urandom_range(1, 4) : 0;
            gap       = $urandom_range(1, 4);
            pulse     = (sel < 25) ? $urandom_range(40, 200) : $urandom_range(1, 40);
            send_tick(1'b1, 1'($urandom_range(1)));
            repeat (trig_span + 1)
                send_tick($urandom_range(3) == 0, 1'($urandom_range(1)));
            repeat (pre) send_tick($urandom_range(3) == 0, 1'b1);
            repeat (gap) send_tick($urandom_range(3) == 0, 1'b0);
            repeat (pulse) send_tick($urandom_range(3) == 0, 1'b1);
            send_tick($urandom_range(3) == 0, 1'b0);
        end
    endtask

    task automatic run_phase(input int trig, input int budget_ticks, input int cm,
                             input int inch, input int idle_pct, input int stall_pct,
                             input int n_ticks);
        int first;
        settle();
        program_ranger(trig, budget_ticks, cm, inch);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first          = tick_count;
        while (tick_count - first < n_ticks) random_sequence();
    endtask

    initial begin
        tick_ch.valid      = 1'b0;
        tick_ch.cmd        = 1'b0;
        tick_ch.echo_level = 1'b0;
        word_ch.ready      = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: shortest trigger, tight budget, extreme divisors
        program_ranger(1, 8, 1, 255);
        // Idle ticks with both echo levels
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        // Pulse already high when listening begins; starts while busy are dropped
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        // No echo at all: runs out the budget
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        repeat (8) send_tick(1'b0, 1'b0);

        // Random phases, each with its own settings and idling mix
        run_phase(1, 60, 1, 1, 0, 0, 160);
        run_phase(3, 1048575, 255, 255, 51, 0, 160);
        // Zero trigger, zero budget and zero divisors
        run_phase(0, 0, 0, 0, 0, 51, 80);
        run_phase(2, 200, 0, 7, 18, 18, 160);
        // Long trigger, default divisors: one long measurement
        run_phase(300, 40, int'(uer_pkg::RST_TICKS_PER_CM), int'(uer_pkg::RST_TICKS_PER_INCH),
                  18, 18, 20);

        settle();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
rtl/uer_pkg.sv
rtl/uer_if.sv
rtl/uer_ctrl.sv
rtl/uer_dp.sv
rtl/ultrasonic_echo_ranger_top.sv
test/uer_ranger_checker.sv
test/ultrasonic_echo_ranger_top_tb.sv
